[sv/ibps_pkg.sv]
// Shared types, constants and defaults of the padded image frame store.
`timescale 1ns / 1ps

package ibps_pkg;

  // Default store geometry, handed to the top level parameters.
  localparam int DEF_MAX_WIDTH    = 256;
  localparam int DEF_MAX_HEIGHT   = 256;
  localparam int DEF_MAX_CHANNELS = 4;

  // Field and register widths fixed by the interface.
  localparam int COL_W      = 10;
  localparam int CHAN_W     = 2;
  localparam int PIX_W      = 8;
  localparam int DIM_W      = 9;
  localparam int NCH_W      = 3;
  localparam int PAD_W      = 8;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // Signed offset from the image origin, and its magnitude for the modulo unit.
  localparam int OFS_W      = COL_W + 1;
  localparam int MOD_W      = COL_W;
  localparam int DIV_CNT_W  = $clog2(MOD_W + 1);

  // Register reset values.
  localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH   = 9'd256;
  localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT  = 9'd256;
  localparam logic [NCH_W-1:0]  RST_CHANNEL_COUNT = 3'd1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_CHANNEL_COUNT = 3'd2,
    REG_PAD_WIDTH     = 3'd3,
    REG_PAD_HEIGHT    = 3'd4,
    REG_PAD_MODE      = 3'd5
  } cfg_reg_t;

  // Border rules.
  typedef enum logic [MODE_W-1:0] {
    PAD_ZERO      = 2'd0,
    PAD_REPLICATE = 2'd1,
    PAD_MIRROR    = 2'd2
  } pad_mode_t;

  // Item actions.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Input beat.
  typedef struct packed {
    logic              action;
    logic [COL_W-1:0]  col;
    logic [COL_W-1:0]  row;
    logic [CHAN_W-1:0] channel;
    logic [PIX_W-1:0]  value;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             status;
  } out_beat_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic eval;
    logic mod_start;
    logic map;
    logic addr;
    logic mem;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic err;
    logic need_mod;
    logic div_done;
  } stat_t;

endpackage

[sv/ibps_mod_unit.sv]
// Iterative restoring remainder unit: dividend mod divisor, one bit per cycle.
`timescale 1ns / 1ps

module ibps_mod_unit
  import ibps_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MOD_W-1:0] dividend,
  input  logic [MOD_W-1:0] divisor,
  output logic             done,
  output logic [MOD_W-1:0] rem
);

  logic                 run_r, run_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MOD_W-1:0]     rem_r, rem_nxt;
  logic [MOD_W-1:0]     dvd_r, dvd_nxt;
  logic [MOD_W-1:0]     dvs_r, dvs_nxt;
  logic [MOD_W:0]       shifted;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    run_nxt = run_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    dvs_nxt = dvs_r;
    shifted = {rem_r, dvd_r[MOD_W-1]};
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = DIV_CNT_W'(MOD_W);
      rem_nxt = '0;
      dvd_nxt = dividend;
      dvs_nxt = divisor;
    end else if (run_r) begin
      dvd_nxt = {dvd_r[MOD_W-2:0], 1'b0};
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = MOD_W'(shifted - {1'b0, dvs_r});
      end else begin
        rem_nxt = shifted[MOD_W-1:0];
      end
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        run_nxt = 1'b0;
      end
    end
  end

  // Control state resets; operand registers do not need to.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = !run_r;
  assign rem  = rem_r;

endmodule

[sv/ibps_ctrl.sv]
// Controller state machine that sequences one item through the datapath.
`timescale 1ns / 1ps

module ibps_ctrl
  import ibps_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  out_valid
);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_EVAL     = 7'b0000010,
    ST_DIV_WAIT = 7'b0000100,
    ST_MAP      = 7'b0001000,
    ST_ADDR     = 7'b0010000,
    ST_MEM      = 7'b0100000,
    ST_RESP     = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (stat.err) begin
          state_nxt = ST_RESP;
        end else if (stat.need_mod) begin
          cmd.mod_start = 1'b1;
          state_nxt     = ST_DIV_WAIT;
        end else begin
          state_nxt = ST_MAP;
        end
      end
      ST_DIV_WAIT: begin
        if (stat.div_done) begin
          state_nxt = ST_MAP;
        end
      end
      ST_MAP: begin
        cmd.map   = 1'b1;
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        cmd.addr  = 1'b1;
        state_nxt = ST_MEM;
      end
      ST_MEM: begin
        cmd.mem   = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_RESP);

endmodule

[sv/ibps_datapath.sv]
// Datapath: configuration registers, range checks, index mapping and the pixel memory.
`timescale 1ns / 1ps

module ibps_datapath
  import ibps_pkg::*;
#(
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_beat_t              in_data,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  output out_beat_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
  localparam int ADDR_W = $clog2(DEPTH);

  // Configuration registers.
  logic [DIM_W-1:0]  img_w_r, img_h_r;
  logic [NCH_W-1:0]  nch_r;
  logic [PAD_W-1:0]  pad_w_r, pad_h_r;
  logic [MODE_W-1:0] mode_r;

  // Item registers.
  in_beat_t                req_r;
  logic signed [OFS_W-1:0] x_r, y_r;
  logic                    inside_r, err_r, use_store_r;
  logic [DIM_W-1:0]        map_x_r, map_y_r;
  logic [ADDR_W-1:0]       addr_r;
  logic [PIX_W-1:0]        rd_q_r;
  logic [PIX_W-1:0]        mem [DEPTH];

  // Evaluation signals.
  logic [DIM_W-1:0]        w_sat, h_sat;
  logic [NCH_W-1:0]        nch_sat;
  logic signed [OFS_W-1:0] x_c, y_c;
  logic                    xin_c, yin_c, inside_c, err_c, use_store_c;
  logic                    is_wr, ch_bad;
  logic [OFS_W-1:0]        frame_w, frame_h;
  logic [MOD_W-1:0]        ax_c, ay_c, divisor;
  logic [MOD_W-1:0]        rem_x, rem_y;
  logic                    done_x, done_y;
  logic [DIM_W-1:0]        map_x_nxt, map_y_nxt;

  // Nearest edge index for an offset from the origin.
  function automatic logic [DIM_W-1:0] clamp_idx(input logic signed [OFS_W-1:0] x,
                                                 input logic [DIM_W-1:0] n);
    logic [DIM_W-1:0] res;
    if (x[OFS_W-1]) begin
      res = '0;
    end else if (x[OFS_W-2:0] >= {1'b0, n}) begin
      res = n - DIM_W'(1);
    end else begin
      res = x[DIM_W-1:0];
    end
    return res;
  endfunction

  // Reflect a remainder m of |x| mod 2n into 0..n-1, with negatives held at zero.
  function automatic logic [DIM_W-1:0] mirror_idx(input logic [MOD_W-1:0] m,
                                                  input logic [DIM_W-1:0] n);
    logic signed [MOD_W+1:0] m_s;
    logic signed [MOD_W+1:0] other;
    logic signed [MOD_W+1:0] r;
    m_s   = $signed({2'b00, m});
    other = $signed({2'b00, n, 1'b0}) - $signed((MOD_W+2)'(2)) - m_s;
    r     = (m_s < other) ? m_s : other;
    return r[MOD_W+1] ? '0 : r[DIM_W-1:0];
  endfunction

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= RST_IMAGE_WIDTH;
      img_h_r <= RST_IMAGE_HEIGHT;
      nch_r   <= RST_CHANNEL_COUNT;
      pad_w_r <= '0;
      pad_h_r <= '0;
      mode_r  <= PAD_ZERO;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   img_w_r <= cfg_wdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT:  img_h_r <= cfg_wdata[DIM_W-1:0];
        REG_CHANNEL_COUNT: nch_r   <= cfg_wdata[NCH_W-1:0];
        REG_PAD_WIDTH:     pad_w_r <= cfg_wdata[PAD_W-1:0];
        REG_PAD_HEIGHT:    pad_h_r <= cfg_wdata[PAD_W-1:0];
        REG_PAD_MODE:      mode_r  <= cfg_wdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register values saturated into their legal ranges.
  always_comb begin
    if (img_w_r == '0) begin
      w_sat = DIM_W'(1);
    end else if (int'(img_w_r) > MAX_WIDTH) begin
      w_sat = DIM_W'(MAX_WIDTH);
    end else begin
      w_sat = img_w_r;
    end
    if (img_h_r == '0) begin
      h_sat = DIM_W'(1);
    end else if (int'(img_h_r) > MAX_HEIGHT) begin
      h_sat = DIM_W'(MAX_HEIGHT);
    end else begin
      h_sat = img_h_r;
    end
    if (nch_r == '0) begin
      nch_sat = NCH_W'(1);
    end else if (int'(nch_r) > MAX_CHANNELS) begin
      nch_sat = NCH_W'(MAX_CHANNELS);
    end else begin
      nch_sat = nch_r;
    end
  end

  // Range checks and offsets into the image for the latched beat.
  always_comb begin
    is_wr    = (req_r.action == ACT_WRITE);
    x_c      = $signed({1'b0, req_r.col}) - $signed({3'b000, pad_w_r});
    y_c      = $signed({1'b0, req_r.row}) - $signed({3'b000, pad_h_r});
    xin_c    = !x_c[OFS_W-1] && (x_c[OFS_W-2:0] < {1'b0, w_sat});
    yin_c    = !y_c[OFS_W-1] && (y_c[OFS_W-2:0] < {1'b0, h_sat});
    inside_c = xin_c && yin_c;
    frame_w  = {2'b00, w_sat} + {2'b00, pad_w_r, 1'b0};
    frame_h  = {2'b00, h_sat} + {2'b00, pad_h_r, 1'b0};
    ch_bad   = ({1'b0, req_r.channel} >= nch_sat);
    if (is_wr) begin
      err_c = (req_r.col >= {1'b0, w_sat}) || (req_r.row >= {1'b0, h_sat}) || ch_bad;
    end else begin
      err_c = ({1'b0, req_r.col} >= frame_w) || ({1'b0, req_r.row} >= frame_h) || ch_bad;
    end
    use_store_c = !is_wr && !err_c &&
                  (inside_c || (mode_r == PAD_REPLICATE) || (mode_r == PAD_MIRROR));
    ax_c    = MOD_W'(x_c[OFS_W-1] ? -x_c : x_c);
    ay_c    = MOD_W'(y_c[OFS_W-1] ? -y_c : y_c);
    divisor = {w_sat, 1'b0};
  end

  assign stat.err      = err_c;
  assign stat.need_mod = !is_wr && !err_c && !inside_c && (mode_r == PAD_MIRROR);
  assign stat.div_done = done_x && done_y;

  // Column and row remainders modulo twice the image size.
  ibps_mod_unit u_mod_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mod_start),
    .dividend (ax_c),
    .divisor  (divisor),
    .done     (done_x),
    .rem      (rem_x)
  );

  ibps_mod_unit u_mod_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mod_start),
    .dividend (ay_c),
    .divisor  ({h_sat, 1'b0}),
    .done     (done_y),
    .rem      (rem_y)
  );

  // Stored index for the beat: raw on write or inside, else by border rule.
  always_comb begin
    if (req_r.action == ACT_WRITE) begin
      map_x_nxt = req_r.col[DIM_W-1:0];
      map_y_nxt = req_r.row[DIM_W-1:0];
    end else if (inside_r) begin
      map_x_nxt = x_r[DIM_W-1:0];
      map_y_nxt = y_r[DIM_W-1:0];
    end else if (mode_r == PAD_REPLICATE) begin
      map_x_nxt = clamp_idx(x_r, w_sat);
      map_y_nxt = clamp_idx(y_r, h_sat);
    end else begin
      map_x_nxt = mirror_idx(rem_x, w_sat);
      map_y_nxt = mirror_idx(rem_y, h_sat);
    end
  end

  // Item pipeline registers, loaded under controller commands.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.eval) begin
      x_r         <= x_c;
      y_r         <= y_c;
      inside_r    <= inside_c;
      err_r       <= err_c;
      use_store_r <= use_store_c;
    end
    if (cmd.map) begin
      map_x_r <= map_x_nxt;
      map_y_r <= map_y_nxt;
    end
    if (cmd.addr) begin
      addr_r <= ADDR_W'((ADDR_W'(map_y_r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(map_x_r))
                        * ADDR_W'(MAX_CHANNELS) + ADDR_W'(req_r.channel));
    end
  end

  // Pixel memory: one write or one registered read per item.
  always_ff @(posedge clk) begin
    if (cmd.mem && (req_r.action == ACT_WRITE)) begin
      mem[addr_r] <= req_r.value;
    end
    if (cmd.mem && use_store_r) begin
      rd_q_r <= mem[addr_r];
    end
  end

  assign out_data.pixel  = use_store_r ? rd_q_r : '0;
  assign out_data.status = err_r;

endmodule

[sv/image_border_padding_store.sv]
// Top level of the frame store with zero, replicate and mirror padded reads.
//
//   Channel  Ports                          Handshake
//   input    start, busy, in_data           beat taken when start and !busy
//   result   out_valid, out_data            one-cycle strobe, always taken
//   config   cfg_we, cfg_index, cfg_wdata   write when cfg_we is high
//
// A write beat, or a read that needs no mirroring, passes the eval, map, address and memory
// states before its result is shown; the next beat is taken only once the block is idle again.
// A mirrored read outside the image also waits in a divide state for the one-bit-per-cycle
// remainder units; a beat out of range goes from eval straight to the result.
// Reset clears the controller and the configuration registers; the item registers and the pixel memory have no reset.
// The result side cannot stall, so the result strobe is never held.
`timescale 1ns / 1ps

module image_border_padding_store
  import ibps_pkg::*;
#(
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  output out_beat_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  ibps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Registers, index mapping and memory.
  ibps_datapath #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule

[sv/ibps_checker.sv]
// Port-level checker for the padded frame store, bound to the top level.
`timescale 1ns / 1ps

module ibps_checker
  import ibps_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_beat_t out_data
);

  // A taken beat keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after a beat was taken");

  // A result lasts a single cycle.
  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // Results only appear while an item is in flight.
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result shown while idle");

  // A rejected beat returns a zero pixel.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status) |-> (out_data.pixel == '0))
    else $error("nonzero pixel on an out-of-range result");

endmodule

bind image_border_padding_store ibps_checker u_ibps_checker (.*);

[verif/tb_image_border_padding_store.sv]
// Self-checking testbench of the frame store: pixel writes and zero, replicate and mirror reads.
`timescale 1ns / 1ps

module tb_image_border_padding_store;
  import ibps_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT  = 10;
  localparam int STORE_DEPTH   = DEF_MAX_WIDTH * DEF_MAX_HEIGHT * DEF_MAX_CHANNELS;

  // What a beat touches: nothing (out of range), no byte (zero border) or one stored byte.
  typedef enum logic [1:0] {
    LOOK_BAD,
    LOOK_BLANK,
    LOOK_MEM
  } lookup_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_beat_t              in_data;
  logic                  out_valid;
  out_beat_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Shadow copy of the registers, kept raw as written.
  logic [DIM_W-1:0]  sh_width;
  logic [DIM_W-1:0]  sh_height;
  logic [NCH_W-1:0]  sh_channels;
  logic [PAD_W-1:0]  sh_pad_w;
  logic [PAD_W-1:0]  sh_pad_h;
  logic [MODE_W-1:0] sh_mode;

  // Shadow copy of the pixel memory and which bytes have been written.
  logic [PIX_W-1:0] frame_bytes [STORE_DEPTH];
  bit               frame_written [STORE_DEPTH];

  out_beat_t pending_pixels [$];
  int        fail_count  = 0;
  int        cycle_count = 0;
  int        idle_pct    = 0;
  int        sent_count  = 0;

  image_border_padding_store u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("ERROR: %s", msg);
  endfunction

  // Every result beat is matched against the oldest expected one.
  always @(posedge clk) begin : result_check
    out_beat_t want;
    if (rst_n && out_valid) begin
      if (pending_pixels.size() == 0) begin
        note_failure($sformatf("unexpected result beat: pixel %02h status %0b",
                               out_data.pixel, out_data.status));
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.pixel !== want.pixel || out_data.status !== want.status) begin
          note_failure($sformatf("pixel %02h status %0b, expected pixel %02h status %0b",
                                 out_data.pixel, out_data.status, want.pixel, want.status));
        end
      end
    end
  end

  function automatic int sat_dim(input int v, input int hi);
    return (v < 1) ? 1 : (v > hi) ? hi : v;
  endfunction

  // Reflect about the edges without repeating them; clamp the result at zero.
  function automatic int mirror_fold(input int x, input int n);
    int m;
    int other;
    m = ((x < 0) ? -x : x) % (2 * n);
    other = 2 * n - 2 - m;
    if (other < m) m = other;
    return (m < 0) ? 0 : m;
  endfunction

  function automatic int edge_clamp(input int x, input int n);
    return (x < 0) ? 0 : (x >= n) ? n - 1 : x;
  endfunction

  // Finds the stored byte that a beat writes or reads, under the shadow registers.
  function automatic lookup_t locate_byte(input in_beat_t b, output int addr);
    int w;
    int h;
    int nch;
    int pw;
    int ph;
    int ch;
    int x;
    int y;
    w   = sat_dim(sh_width, DEF_MAX_WIDTH);
    h   = sat_dim(sh_height, DEF_MAX_HEIGHT);
    nch = sat_dim(sh_channels, DEF_MAX_CHANNELS);
    pw  = sh_pad_w;
    ph  = sh_pad_h;
    ch  = b.channel;
    x   = b.col;
    y   = b.row;
    addr = 0;
    if (b.action == ACT_WRITE) begin
      if (x >= w || y >= h || ch >= nch) return LOOK_BAD;
    end else begin
      if (x >= w + 2 * pw || y >= h + 2 * ph || ch >= nch) return LOOK_BAD;
      x = x - pw;
      y = y - ph;
      if (x < 0 || x >= w || y < 0 || y >= h) begin
        if (sh_mode == PAD_REPLICATE) begin
          x = edge_clamp(x, w);
          y = edge_clamp(y, h);
        end else if (sh_mode == PAD_MIRROR) begin
          x = mirror_fold(x, w);
          y = mirror_fold(y, h);
        end else begin
          return LOOK_BLANK;
        end
      end
    end
    addr = (y * DEF_MAX_WIDTH + x) * DEF_MAX_CHANNELS + ch;
    return LOOK_MEM;
  endfunction

  // Expected result of one accepted beat; a good write also updates the shadow memory.
  function automatic out_beat_t frame_response(input in_beat_t b);
    out_beat_t r;
    lookup_t   kind;
    int        addr;
    kind = locate_byte(b, addr);
    r.pixel  = '0;
    r.status = (kind == LOOK_BAD);
    if (kind == LOOK_MEM) begin
      if (b.action == ACT_WRITE) begin
        frame_bytes[addr]   = b.value;
        frame_written[addr] = 1'b1;
      end else begin
        r.pixel = frame_bytes[addr];
      end
    end
    return r;
  endfunction

  // Sends one beat after a random gap. Returns on the falling edge after it was taken,
  // with start still high, so the caller must drive start at that edge.
  task automatic send_beat(input in_beat_t b);
    bit taken;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= b;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    pending_pixels.push_back(frame_response(b));
    sent_count++;
    @(negedge clk);
  endtask

  task automatic put_pixel(input int col, input int row, input int ch, input int val);
    in_beat_t b;
    b.action  = ACT_WRITE;
    b.col     = col[COL_W-1:0];
    b.row     = row[COL_W-1:0];
    b.channel = ch[CHAN_W-1:0];
    b.value   = val[PIX_W-1:0];
    send_beat(b);
  endtask

  // A read that lands on a byte never written gets that byte written first.
  task automatic get_pixel(input int col, input int row, input int ch);
    in_beat_t b;
    int       addr;
    b.action  = ACT_READ;
    b.col     = col[COL_W-1:0];
    b.row     = row[COL_W-1:0];
    b.channel = ch[CHAN_W-1:0];
    b.value   = $urandom_range(255);
    if (locate_byte(b, addr) == LOOK_MEM && !frame_written[addr]) begin
      put_pixel((addr / DEF_MAX_CHANNELS) % DEF_MAX_WIDTH,
                addr / (DEF_MAX_WIDTH * DEF_MAX_CHANNELS),
                addr % DEF_MAX_CHANNELS, $urandom_range(255));
    end
    send_beat(b);
  endtask

  // Holds off new beats until every expected result has come and the block is idle.
  task automatic settle();
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    case (idx)
      REG_IMAGE_WIDTH:   sh_width    = val[DIM_W-1:0];
      REG_IMAGE_HEIGHT:  sh_height   = val[DIM_W-1:0];
      REG_CHANNEL_COUNT: sh_channels = val[NCH_W-1:0];
      REG_PAD_WIDTH:     sh_pad_w    = val[PAD_W-1:0];
      REG_PAD_HEIGHT:    sh_pad_h    = val[PAD_W-1:0];
      REG_PAD_MODE:      sh_mode     = val[MODE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic configure(input int w, input int h, input int nch,
                           input int pw, input int ph, input int mode);
    settle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_CHANNEL_COUNT, nch);
    write_reg(REG_PAD_WIDTH, pw);
    write_reg(REG_PAD_HEIGHT, ph);
    write_reg(REG_PAD_MODE, mode);
    cfg_we <= 1'b0;
  endtask

  function automatic int pick4(input int a, input int b, input int c, input int d);
    case ($urandom_range(3))
      0:       return a;
      1:       return b;
      2:       return c;
      default: return d;
    endcase
  endfunction

  // Reset geometry: corners of the full 256x256 image and out-of-range beats.
  task automatic test_reset_geometry();
    put_pixel(0, 0, 0, 8'h00);
    put_pixel(255, 255, 0, 8'hFF);
    put_pixel(256, 0, 0, 8'h11);
    put_pixel(1023, 1023, 3, 8'hAA);
    put_pixel(0, 0, 1, 8'h55);
    get_pixel(0, 0, 0);
    get_pixel(255, 255, 0);
    get_pixel(1023, 0, 0);
    get_pixel(0, 0, 3);
  endtask

  // Each border rule, plus the unused mode code, on a small four-channel image.
  task automatic test_border_modes();
    int modes [4];
    modes = '{PAD_ZERO, PAD_REPLICATE, PAD_MIRROR, 3};
    foreach (modes[i]) begin
      configure(3, 2, 4, 2, 1, modes[i]);
      get_pixel(0, 0, 3);
      get_pixel(1, 2, 2);
    end
  endtask

  // Mirror cases where the reflected index would go negative, and the widest padding.
  task automatic test_mirror_edges();
    configure(1, 1, 1, 3, 3, PAD_MIRROR);
    get_pixel(6, 6, 0);
    configure(4, 2, 2, 7, 0, PAD_MIRROR);
    get_pixel(0, 0, 1);
    get_pixel(14, 1, 0);
    configure(256, 1, 1, 255, 255, PAD_MIRROR);
    get_pixel(0, 0, 0);
    get_pixel(765, 510, 0);
    get_pixel(766, 0, 0);
  endtask

  // Register values outside their range saturate.
  task automatic test_register_saturation();
    configure(0, 511, 0, 1, 1, 3);
    put_pixel(0, 255, 0, 8'h3C);
    get_pixel(1, 256, 0);
    configure(511, 0, 7, 0, 0, PAD_REPLICATE);
    put_pixel(255, 0, 3, 8'hC3);
    get_pixel(255, 0, 3);
    put_pixel(0, 1, 0, 8'h01);
  endtask

  // One random beat: mostly good coordinates, some anywhere in the field ranges.
  task automatic random_item();
    int w;
    int h;
    int nch;
    w   = sat_dim(sh_width, DEF_MAX_WIDTH);
    h   = sat_dim(sh_height, DEF_MAX_HEIGHT);
    nch = sat_dim(sh_channels, DEF_MAX_CHANNELS);
    if ($urandom_range(99) < 40) begin
      if ($urandom_range(99) < 85)
        put_pixel($urandom_range(w - 1), $urandom_range(h - 1), $urandom_range(nch - 1),
                  $urandom_range(255));
      else
        put_pixel($urandom_range(1023), $urandom_range(1023), $urandom_range(3),
                  $urandom_range(255));
    end else begin
      if ($urandom_range(99) < 85)
        get_pixel($urandom_range(w + 2 * int'(sh_pad_w) - 1),
                  $urandom_range(h + 2 * int'(sh_pad_h) - 1), $urandom_range(nch - 1));
      else
        get_pixel($urandom_range(1023), $urandom_range(1023), $urandom_range(3));
    end
  endtask

  // Random settings, mostly small images, now and then the extremes of every register.
  // Every beat sent counts, including the writes that precede reads of fresh bytes.
  task automatic test_random(input int pct, input int n_items);
    int done;
    int phase_len;
    int base;
    base = sent_count;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(7) == 0)
        configure(pick4(0, 1, 256, 511), pick4(0, 1, 256, 511), pick4(0, 1, 4, 7),
                  pick4(0, 1, 255, 255), pick4(0, 1, 255, 255), $urandom_range(3));
      else
        configure($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 4),
                  $urandom_range(6), $urandom_range(6), $urandom_range(3));
      idle_pct = pct;
      phase_len = $urandom_range(20, 80);
      for (int i = 0; i < phase_len && done < n_items; i++) begin
        random_item();
        done = sent_count - base;
      end
      idle_pct = 0;
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    sh_width    = RST_IMAGE_WIDTH;
    sh_height   = RST_IMAGE_HEIGHT;
    sh_channels = RST_CHANNEL_COUNT;
    sh_pad_w    = '0;
    sh_pad_h    = '0;
    sh_mode     = PAD_ZERO;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_geometry();
    test_border_modes();
    test_mirror_edges();
    test_register_saturation();
    test_random(0, 600);
    test_random(53, 550);
    test_random(14, 550);

    settle();
    if (fail_count == 0 && pending_pixels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
sv/ibps_pkg.sv
sv/ibps_mod_unit.sv
sv/ibps_ctrl.sv
sv/ibps_datapath.sv
sv/image_border_padding_store.sv
sv/ibps_checker.sv
verif/tb_image_border_padding_store.sv
